// File: hdl/ray_refraction_defines.svh
// assertion macros for the ray refraction block
`ifndef RAY_REFRACTION_DEFINES_SVH
`define RAY_REFRACTION_DEFINES_SVH

// clocked check, off while reset is asserted
`define RR_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define RR_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rr_pkg.sv
package rr_pkg;

    // field widths
    localparam int DIR_W = 32;
    localparam int NRM_W = 18;
    localparam int IDX_W = 16;
    localparam int THR_W = 17;
    localparam int OUT_W = 32;

    // stream widths
    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 96;
    localparam int OUT_USER_W = 2;

    // square root widths (input bits, root has half)
    localparam int ROOT1_W = 64;
    localparam int ROOT2_W = 48;

    // normalized direction quotient bits
    localparam int Q_W = 17;

    localparam logic [THR_W-1:0] THR_RESET = 17'd1;

    // round to nearest, ties away from zero, arithmetic right shift
    function automatic logic signed [63:0] rshr(input logic signed [63:0] x,
                                                input int unsigned sh);
        logic signed [63:0] half;
        logic signed [63:0] adj;
        half = 64'sd1 <<< (sh - 1);
        adj  = (x < 0) ? 64'sd1 : 64'sd0;
        return (x + half - adj) >>> sh;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic [OUT_W-1:0] sat32(input logic signed [33:0] v);
        logic signed [33:0] vmax;
        logic signed [33:0] vmin;
        vmax = 34'sd2147483647;
        vmin = -34'sd2147483648;
        if (v > vmax)
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < vmin)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// File: hdl/rr_isqrt.sv
module rr_isqrt #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           en,
    input  logic [W-1:0]   x,
    output logic [W/2-1:0] root
);

    localparam int H = W / 2;

    logic [W-1:0] rem_reg [H];
    logic [H-1:0] res_reg [H];

    // one root bit per stage, most significant first
    for (genvar s = 0; s < H; s++)
    begin : g_step
        localparam int B = H - 1 - s;
        logic [W-1:0] rem_in;
        logic [H-1:0] res_in;
        logic [W:0]   trial;

        if (s == 0)
        begin : g_first
            assign rem_in = x;
            assign res_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[s-1];
            assign res_in = res_reg[s-1];
        end

        assign trial = ((W+1)'(res_in) << (B + 1)) | ((W+1)'(1) << (2 * B));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_reg[s] <= W'({1'b0, rem_in} - trial);
                    res_reg[s] <= res_in | (H'(1) << B);
                end
                else
                begin
                    rem_reg[s] <= rem_in;
                    res_reg[s] <= res_in;
                end
            end
        end
    end

    assign root = res_reg[H-1];

endmodule

// File: hdl/ray_refraction.sv
// ray_refraction: Snell refraction of a ray at a surface, with mirror
// reflection when refraction is not possible (total internal reflection).
// Input stream s_t*: one item per ray carries the incident direction, the
// unit surface normal and the index ratio. Output stream m_t*: one item
// per ray with the outgoing direction in tdata and two flags in tuser.
// cfg_wr_en / cfg_wr_data write the threshold on cosT squared; write it only while
// no ray is in flight.
// Throughput: one ray per cycle while s_tready is high. The pipeline's
// length comes from the two bit-per-stage square roots (32 and 24
// stages) and the 17-stage restoring divider that normalizes the
// direction.
// Stalls: the whole pipeline moves on one enable. A result that meets a
// stalled output goes to a one-entry skid register; while that register
// is full s_tready is low and the pipeline holds, so nothing is lost.
// Reset: clears all valid bits, including those of the output and skid
// registers, and sets the threshold to 1.
`include "ray_refraction_defines.svh"

module ray_refraction (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, index_ratio, pad
    input  logic [rr_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_x, out_y, out_z
    output logic [rr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // total_reflection, degenerate
    output logic [rr_pkg::OUT_USER_W-1:0]   m_tuser,
    input  logic                            cfg_wr_en,
    input  logic [rr_pkg::THR_W-1:0]        cfg_wr_data
);

    localparam int H1     = rr_pkg::ROOT1_W / 2;
    localparam int H2     = rr_pkg::ROOT2_W / 2;
    localparam int QW     = rr_pkg::Q_W;
    localparam int PIPE_N = 5 + H1 + 1 + QW + 7 + H2 + 2;

    typedef struct packed {
        logic             zero;
        logic [2:0]       neg;
        logic [2:0][17:0] nv;
        logic [15:0]      n;
    } ctx_t;

    typedef struct packed {
        ctx_t             ctx;
        logic [2:0][31:0] mag;
    } pre_t;

    typedef struct packed {
        ctx_t             ctx;
        logic             tir;
        logic [26:0]      ncr;
        logic [2:0][25:0] orefl;
        logic [2:0][22:0] vnr;
    } mid_t;

    // handshake control
    logic                 adv;
    logic [PIPE_N-1:0]    vld_reg;
    logic                 out_valid_reg;
    logic                 skid_valid_reg;
    logic [rr_pkg::THR_W-1:0] thr_reg;

    assign adv      = !skid_valid_reg;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= rr_pkg::THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_N-2:0], s_tvalid};
        end
    end

    // stage 0: input register
    logic [rr_pkg::IN_DATA_W-1:0] s0_data_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_data_reg <= s_tdata;
        end
    end

    // stage 1: magnitudes, zero check, first normalize steps
    logic [31:0] d0 [3];
    logic [31:0] mg0 [3];
    logic [31:0] mg_a [3];
    logic [31:0] mg_b [3];
    logic [31:0] m0, m_a, m_b;
    logic        lz16, lz8;
    ctx_t        c0;
    logic [31:0] s1_mag_reg [3];
    logic [31:0] s1_m_reg;
    ctx_t        s1_ctx_reg;

    always_comb
    begin
        d0[0] = s0_data_reg[31:0];
        d0[1] = s0_data_reg[63:32];
        d0[2] = s0_data_reg[95:64];
        c0.nv[0] = s0_data_reg[113:96];
        c0.nv[1] = s0_data_reg[131:114];
        c0.nv[2] = s0_data_reg[149:132];
        c0.n     = s0_data_reg[165:150];
        for (int i = 0; i < 3; i++)
        begin
            c0.neg[i] = d0[i][31];
            mg0[i]    = d0[i][31] ? 32'(-d0[i]) : d0[i];
        end
        m0 = (mg0[0] > mg0[1]) ? mg0[0] : mg0[1];
        m0 = (mg0[2] > m0) ? mg0[2] : m0;
        c0.zero = (m0 == '0);
        lz16 = (m0[31:14] == '0);
        m_a  = lz16 ? (m0 << 16) : m0;
        lz8  = (m_a[31:22] == '0);
        m_b  = lz8 ? (m_a << 8) : m_a;
        for (int i = 0; i < 3; i++)
        begin
            mg_a[i] = lz16 ? (mg0[i] << 16) : mg0[i];
            mg_b[i] = lz8 ? (mg_a[i] << 8) : mg_a[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg <= mg_b;
            s1_m_reg   <= m_b;
            s1_ctx_reg <= c0;
        end
    end

    // stage 2: last normalize steps, largest magnitude reaches bit 29
    logic [31:0] mg_c [3];
    logic [31:0] m_c, m_d;
    logic        lz4, lz2, lz1;
    logic [31:0] s2_mag_reg [3];
    ctx_t        s2_ctx_reg;

    always_comb
    begin
        lz4 = (s1_m_reg[31:26] == '0);
        m_c = lz4 ? (s1_m_reg << 4) : s1_m_reg;
        lz2 = (m_c[31:28] == '0);
        m_d = lz2 ? (m_c << 2) : m_c;
        lz1 = (m_d[31:29] == '0);
        for (int i = 0; i < 3; i++)
        begin
            mg_c[i] = lz4 ? (s1_mag_reg[i] << 4) : s1_mag_reg[i];
            mg_c[i] = lz2 ? (mg_c[i] << 2) : mg_c[i];
            mg_c[i] = lz1 ? (mg_c[i] << 1) : mg_c[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_mag_reg <= mg_c;
            s2_ctx_reg <= s1_ctx_reg;
        end
    end

    // stage 3: squares
    logic [63:0] s3_sq_reg [3];
    logic [31:0] s3_mag_reg [3];
    ctx_t        s3_ctx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s3_sq_reg[i] <= 64'(s2_mag_reg[i]) * 64'(s2_mag_reg[i]);
            end
            s3_mag_reg <= s2_mag_reg;
            s3_ctx_reg <= s2_ctx_reg;
        end
    end

    // stage 4: sum of squares
    logic [63:0] s4_sum_reg;
    pre_t        s4_pre_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_sum_reg     <= s3_sq_reg[0] + s3_sq_reg[1] + s3_sq_reg[2];
            s4_pre_reg.ctx <= s3_ctx_reg;
            for (int i = 0; i < 3; i++)
            begin
                s4_pre_reg.mag[i] <= s3_mag_reg[i];
            end
        end
    end

    // length: square root of the sum, context delayed alongside
    logic [H1-1:0] len;
    pre_t          dl1_reg [H1];

    rr_isqrt #(
        .W (rr_pkg::ROOT1_W)
    ) u_len_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    (s4_sum_reg),
        .root (len)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl1_reg[0] <= s4_pre_reg;
            for (int i = 1; i < H1; i++)
            begin
                dl1_reg[i] <= dl1_reg[i-1];
            end
        end
    end

    // stage 5: rounded dividend for each component
    logic [48:0] s5_rem_reg [3];
    logic [31:0] s5_den_reg;
    ctx_t        s5_ctx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_rem_reg[i] <= 49'({dl1_reg[H1-1].mag[i], 16'b0}) + 49'(len[31:1]);
            end
            s5_den_reg <= len;
            s5_ctx_reg <= dl1_reg[H1-1].ctx;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [48:0] dv_rem_reg [QW][3];
    logic [16:0] dv_q_reg [QW][3];
    logic [31:0] dv_den_reg [QW];
    ctx_t        dv_ctx_reg [QW];

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int B = QW - 1 - s;
        logic [48:0] rem_in [3];
        logic [16:0] q_in [3];
        logic [31:0] den_in;
        ctx_t        ctx_in;
        logic [48:0] trial;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                den_in = s5_den_reg;
                ctx_in = s5_ctx_reg;
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = s5_rem_reg[l];
                    q_in[l]   = '0;
                end
            end
        end
        else
        begin : g_next
            always_comb
            begin
                den_in = dv_den_reg[s-1];
                ctx_in = dv_ctx_reg[s-1];
                for (int l = 0; l < 3; l++)
                begin
                    rem_in[l] = dv_rem_reg[s-1][l];
                    q_in[l]   = dv_q_reg[s-1][l];
                end
            end
        end

        assign trial = 49'(den_in) << B;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_den_reg[s] <= den_in;
                dv_ctx_reg[s] <= ctx_in;
                for (int l = 0; l < 3; l++)
                begin
                    if (rem_in[l] >= trial)
                    begin
                        dv_rem_reg[s][l] <= rem_in[l] - trial;
                        dv_q_reg[s][l]   <= q_in[l] | (17'(1) << B);
                    end
                    else
                    begin
                        dv_rem_reg[s][l] <= rem_in[l];
                        dv_q_reg[s][l]   <= q_in[l];
                    end
                end
            end
        end
    end

    // stage 6: signed unit direction, n squared
    logic signed [17:0] s6_v_reg [3];
    logic [31:0]        s6_n2_reg;
    ctx_t               s6_ctx_reg;
    ctx_t               cq;

    assign cq = dv_ctx_reg[QW-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_v_reg[i] <= cq.neg[i] ? -$signed({1'b0, dv_q_reg[QW-1][i]})
                                         : $signed({1'b0, dv_q_reg[QW-1][i]});
            end
            s6_n2_reg  <= 32'(cq.n) * 32'(cq.n);
            s6_ctx_reg <= cq;
        end
    end

    // stage 7: products for the dot and for v*n
    logic signed [35:0] s7_p_reg [3];
    logic signed [34:0] s7_vn_reg [3];
    logic signed [17:0] s7_v_reg [3];
    logic [31:0]        s7_n2_reg;
    ctx_t               s7_ctx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s7_p_reg[i]  <= $signed(s6_ctx_reg.nv[i]) * s6_v_reg[i];
                s7_vn_reg[i] <= s6_v_reg[i] * $signed({1'b0, s6_ctx_reg.n});
            end
            s7_v_reg   <= s6_v_reg;
            s7_n2_reg  <= s6_n2_reg;
            s7_ctx_reg <= s6_ctx_reg;
        end
    end

    // stage 8: V.N and rounded v*n
    logic signed [37:0] psum;
    logic signed [63:0] dot_w;
    logic signed [63:0] vn_w [3];
    logic signed [21:0] s8_dot_reg;
    logic signed [22:0] s8_vnr_reg [3];
    logic signed [17:0] s8_v_reg [3];
    logic [31:0]        s8_n2_reg;
    ctx_t               s8_ctx_reg;

    always_comb
    begin
        psum  = 38'(s7_p_reg[0]) + 38'(s7_p_reg[1]) + 38'(s7_p_reg[2]);
        dot_w = rr_pkg::rshr(64'(psum), 16);
        for (int i = 0; i < 3; i++)
        begin
            vn_w[i] = rr_pkg::rshr(64'(s7_vn_reg[i]), 12);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_dot_reg <= dot_w[21:0];
            for (int i = 0; i < 3; i++)
            begin
                s8_vnr_reg[i] <= vn_w[i][22:0];
            end
            s8_v_reg   <= s7_v_reg;
            s8_n2_reg  <= s7_n2_reg;
            s8_ctx_reg <= s7_ctx_reg;
        end
    end

    // stage 9: cosI squared, n*cosI, reflection products
    logic signed [21:0] cosi;
    logic signed [22:0] two_dot;
    logic signed [43:0] s9_cc_reg;
    logic signed [38:0] s9_ncos_reg;
    logic signed [40:0] s9_rf_reg [3];
    logic signed [22:0] s9_vnr_reg [3];
    logic signed [17:0] s9_v_reg [3];
    logic [31:0]        s9_n2_reg;
    ctx_t               s9_ctx_reg;

    assign cosi    = -s8_dot_reg;
    assign two_dot = 23'(s8_dot_reg) <<< 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s9_cc_reg   <= 44'(cosi) * 44'(cosi);
            s9_ncos_reg <= $signed({1'b0, s8_ctx_reg.n}) * cosi;
            for (int i = 0; i < 3; i++)
            begin
                s9_rf_reg[i] <= $signed(s8_ctx_reg.nv[i]) * two_dot;
            end
            s9_vnr_reg <= s8_vnr_reg;
            s9_v_reg   <= s8_v_reg;
            s9_n2_reg  <= s8_n2_reg;
            s9_ctx_reg <= s8_ctx_reg;
        end
    end

    // stage 10: 1 - cosI^2, rounded n*cosI, reflected direction
    logic signed [63:0] c2_w;
    logic signed [63:0] ncr_w;
    logic signed [63:0] rf_w [3];
    logic signed [28:0] s10_omc_reg;
    logic signed [26:0] s10_ncr_reg;
    logic signed [25:0] s10_orefl_reg [3];
    logic signed [22:0] s10_vnr_reg [3];
    logic [31:0]        s10_n2_reg;
    ctx_t               s10_ctx_reg;

    always_comb
    begin
        c2_w  = rr_pkg::rshr(64'(s9_cc_reg), 16);
        ncr_w = rr_pkg::rshr(64'(s9_ncos_reg), 12);
        for (int i = 0; i < 3; i++)
        begin
            rf_w[i] = rr_pkg::rshr(64'(s9_rf_reg[i]), 16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s10_omc_reg <= 29'sd65536 - $signed(c2_w[28:0]);
            s10_ncr_reg <= ncr_w[26:0];
            for (int i = 0; i < 3; i++)
            begin
                s10_orefl_reg[i] <= 26'(s9_v_reg[i]) - $signed(rf_w[i][25:0]);
            end
            s10_vnr_reg <= s9_vnr_reg;
            s10_n2_reg  <= s9_n2_reg;
            s10_ctx_reg <= s9_ctx_reg;
        end
    end

    // stage 11: n^2 (1 - cosI^2)
    logic signed [61:0] s11_t_reg;
    logic signed [26:0] s11_ncr_reg;
    logic signed [25:0] s11_orefl_reg [3];
    logic signed [22:0] s11_vnr_reg [3];
    ctx_t               s11_ctx_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s11_t_reg     <= 62'($signed({1'b0, s10_n2_reg})) * 62'(s10_omc_reg);
            s11_ncr_reg   <= s10_ncr_reg;
            s11_orefl_reg <= s10_orefl_reg;
            s11_vnr_reg   <= s10_vnr_reg;
            s11_ctx_reg   <= s10_ctx_reg;
        end
    end

    // stage 12: cosT2 and the threshold decision
    logic signed [63:0] t_w;
    logic signed [39:0] cost2;
    logic [47:0]        s12_rad_reg;
    mid_t               s12_mid_reg;

    always_comb
    begin
        t_w   = rr_pkg::rshr(64'(s11_t_reg), 24);
        cost2 = 40'sd65536 - $signed(t_w[39:0]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s12_rad_reg         <= {cost2[31:0], 16'b0};
            s12_mid_reg.ctx     <= s11_ctx_reg;
            s12_mid_reg.tir     <= !(cost2 > $signed(40'(thr_reg)));
            s12_mid_reg.ncr     <= s11_ncr_reg;
            for (int i = 0; i < 3; i++)
            begin
                s12_mid_reg.orefl[i] <= s11_orefl_reg[i];
                s12_mid_reg.vnr[i]   <= s11_vnr_reg[i];
            end
        end
    end

    // sqrt(cosT2), context delayed alongside
    logic [H2-1:0] root2;
    mid_t          dl2_reg [H2];

    rr_isqrt #(
        .W (rr_pkg::ROOT2_W)
    ) u_cost_sqrt (
        .clk  (clk),
        .en   (adv),
        .x    (s12_rad_reg),
        .root (root2)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dl2_reg[0] <= s12_mid_reg;
            for (int i = 1; i < H2; i++)
            begin
                dl2_reg[i] <= dl2_reg[i-1];
            end
        end
    end

    // stage 13: k = n*cosI - sqrt(cosT2)
    logic signed [27:0] s13_k_reg;
    mid_t               s13_mid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s13_k_reg   <= 28'($signed(dl2_reg[H2-1].ncr)) - $signed({4'b0, root2});
            s13_mid_reg <= dl2_reg[H2-1];
        end
    end

    // stage 14: N*k
    logic signed [45:0] s14_nk_reg [3];
    mid_t               s14_mid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s14_nk_reg[i] <= $signed(s13_mid_reg.ctx.nv[i]) * s13_k_reg;
            end
            s14_mid_reg <= s13_mid_reg;
        end
    end

    // final sum, selection and saturation
    logic signed [63:0] nk_w [3];
    logic signed [33:0] o_w [3];
    logic [rr_pkg::OUT_DATA_W-1:0] res_data;
    logic [rr_pkg::OUT_USER_W-1:0] res_user;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nk_w[i] = rr_pkg::rshr(64'(s14_nk_reg[i]), 16);
            if (s14_mid_reg.tir)
            begin
                o_w[i] = 34'($signed(s14_mid_reg.orefl[i]));
            end
            else
            begin
                o_w[i] = 34'($signed(s14_mid_reg.vnr[i])) + 34'($signed(nk_w[i][29:0]));
            end
        end
        if (s14_mid_reg.ctx.zero)
        begin
            res_data = '0;
            res_user = 2'b10;
        end
        else
        begin
            res_data = {rr_pkg::sat32(o_w[2]), rr_pkg::sat32(o_w[1]), rr_pkg::sat32(o_w[0])};
            res_user = {1'b0, s14_mid_reg.tir};
        end
    end

    // output register with one skid entry
    logic [rr_pkg::OUT_DATA_W-1:0] out_data_reg, skid_data_reg;
    logic [rr_pkg::OUT_USER_W-1:0] out_user_reg, skid_user_reg;
    logic                          res_valid;

    assign res_valid = vld_reg[PIPE_N-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
        else
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_user;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // checks
    `RR_ASSERT_ANY(a_skid_has_out, skid_valid_reg |-> out_valid_reg, "skid item without output item")
    `RR_ASSERT_RST(a_skid_fill, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready), "skid filled while output was free")
    `RR_ASSERT_RST(a_degen_zero, m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0], "degenerate item not zero")

endmodule
